### sv/akf_pkg.sv
// Shared types and constants for the angle Kalman filter.
package akf_pkg;

  localparam int CFG_W     = 32;                // noise registers and timestamp
  localparam int LIM_W     = 16;                // innovation clamp register
  localparam int PADDR_W   = 4;                 // three word registers
  localparam int ANGLE_W   = 17;                // angle fields
  localparam int DT_W      = 10;                // clamped time step, 1..1000 ms
  localparam int DT_MAX    = 1000;
  localparam int PROD_W    = CFG_W + DT_W;      // q * dt
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;     // gain reaches exactly one
  localparam int WRAP_W    = 21;                // working angle width
  localparam int MAG_W     = WRAP_W - 1;        // innovation magnitude

  typedef enum logic [1:0] {
    REG_PROCESS_NOISE = 2'd0,
    REG_MEASURE_NOISE = 2'd1,
    REG_MAX_INNOV     = 2'd2
  } akf_reg_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PRED  = 8'b0000_0010,
    S_VADD  = 8'b0000_0100,
    S_GAIN  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_CORR  = 8'b0010_0000,
    S_EWRAP = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } akf_state_t;

  // start strobe handed to a serial unit, done strobe returned
  typedef struct packed {
    logic start;
  } akf_cmd_t;

  typedef struct packed {
    logic done;
  } akf_sts_t;

endpackage

### sv/akf_predict.sv
// Serial process-noise increment: floor(q * dt / 1000), bit-serial multiply then divide.
module akf_predict (
  input  logic                      clk,
  input  logic                      rst,
  input  akf_pkg::akf_cmd_t         cmd,
  input  logic [akf_pkg::CFG_W-1:0] q,
  input  logic [akf_pkg::DT_W-1:0]  dt,
  output logic [akf_pkg::CFG_W-1:0] inc,
  output akf_pkg::akf_sts_t         sts
);
  import akf_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic             busy_mul;
  logic             busy_div;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [PROD_W-1:0] num;
  logic [DT_W-1:0]  rem;
  logic [DT_W-1:0]  dt_sh;
  logic [CFG_W-1:0] q_r;

  logic [PROD_W-1:0] mul_next;
  logic [DT_W:0]     trial;
  logic              qbit;
  logic [DT_W-1:0]   rem_next;

  // multiply: dt bits MSB first; divide: numerator bits MSB first, quotient shifts in below
  always_comb begin
    mul_next = {num[PROD_W-2:0], 1'b0} + (dt_sh[DT_W-1] ? {{DT_W{1'b0}}, q_r} : '0);
    trial    = {rem, num[PROD_W-1]};
    qbit     = (trial >= (DT_W+1)'(DT_MAX));
    rem_next = qbit ? DT_W'(trial - (DT_W+1)'(DT_MAX)) : trial[DT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_mul <= 1'b0;
      busy_div <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy_mul <= 1'b1;
        busy_div <= 1'b0;
        cnt      <= CNT_W'(DT_W);
      end else if (busy_mul) begin
        if (cnt == CNT_W'(1)) begin
          busy_mul <= 1'b0;
          busy_div <= 1'b1;
          cnt      <= CNT_W'(PROD_W);
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end else if (busy_div) begin
        if (cnt == CNT_W'(1)) begin
          busy_div <= 1'b0;
          done     <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num   <= '0;
      rem   <= '0;
      dt_sh <= dt;
      q_r   <= q;
    end else if (busy_mul) begin
      num   <= mul_next;
      dt_sh <= {dt_sh[DT_W-2:0], 1'b0};
    end else if (busy_div) begin
      num <= {num[PROD_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  // quotient is below 2^32 since dt <= 1000
  assign inc      = num[CFG_W-1:0];
  assign sts.done = done;

endmodule

### sv/akf_gain_div.sv
// Restoring divider, one quotient bit per cycle: gain = floor(P * 2^16 / (P + R)).
module akf_gain_div #(
  parameter int VAR_W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  akf_pkg::akf_cmd_t          cmd,
  input  logic [VAR_W-1:0]           p,
  input  logic [akf_pkg::CFG_W-1:0]  r,
  output logic [akf_pkg::GAIN_W-1:0] gain,
  output akf_pkg::akf_sts_t          sts
);
  import akf_pkg::*;

  localparam int SUM_W = ((VAR_W > CFG_W) ? VAR_W : CFG_W) + 1;
  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] d;
  logic [SUM_W:0]   rem;
  logic [GAIN_W-1:0] quo;
  logic             zero_d;

  logic [SUM_W-1:0] d_new;
  logic             ge;
  logic [SUM_W:0]   t;

  always_comb begin
    d_new = {{(SUM_W-VAR_W){1'b0}}, p} + {{(SUM_W-CFG_W){1'b0}}, r};
    ge    = (rem >= {1'b0, d});
    t     = ge ? (rem - {1'b0, d}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(GAIN_W);
      end else if (busy) begin
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // first step tests the integer bit (P == P + R only when R is zero)
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      d      <= d_new;
      rem    <= {{(SUM_W+1-VAR_W){1'b0}}, p};
      zero_d <= (d_new == '0);
    end else if (busy) begin
      rem <= {t[SUM_W-1:0], 1'b0};
      quo <= {quo[GAIN_W-2:0], ge};
    end
  end

  // zero denominator: gain taken as zero
  assign gain     = zero_d ? '0 : quo;
  assign sts.done = done;

endmodule

### sv/akf_update_mul.sv
// Two bit-serial multipliers, one on the gain and one on one minus the gain: correction magnitude and new variance.
module akf_update_mul #(
  parameter int VAR_W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  akf_pkg::akf_cmd_t          cmd,
  input  logic [akf_pkg::GAIN_W-1:0] gain,
  input  logic [akf_pkg::MAG_W-1:0]  mag,
  input  logic [VAR_W-1:0]           p,
  output logic [akf_pkg::MAG_W-1:0]  cmag,
  output logic [VAR_W-1:0]           p_new,
  output akf_pkg::akf_sts_t          sts
);
  import akf_pkg::*;

  localparam int CNT_W  = $clog2(GAIN_W + 1);
  localparam int ACC_CW = MAG_W + GAIN_W;
  localparam int ACC_PW = VAR_W + GAIN_W;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [GAIN_W-1:0] g_sh;
  logic [GAIN_W-1:0] h_sh;
  logic [MAG_W-1:0]  mag_r;
  logic [VAR_W-1:0]  p_r;
  logic [ACC_CW-1:0] acc_c;
  logic [ACC_PW-1:0] acc_p;

  logic [GAIN_W-1:0] one_minus_g;
  logic [ACC_CW-1:0] rounded;

  always_comb begin
    one_minus_g = (GAIN_W'(1) << GAIN_FRAC) - gain;
    rounded     = acc_c + (ACC_CW'(1) << (GAIN_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(GAIN_W);
      end else if (busy) begin
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      g_sh  <= gain;
      h_sh  <= one_minus_g;
      mag_r <= mag;
      p_r   <= p;
      acc_c <= '0;
      acc_p <= '0;
    end else if (busy) begin
      g_sh  <= {g_sh[GAIN_W-2:0], 1'b0};
      h_sh  <= {h_sh[GAIN_W-2:0], 1'b0};
      acc_c <= {acc_c[ACC_CW-2:0], 1'b0}
               + (g_sh[GAIN_W-1] ? {{GAIN_W{1'b0}}, mag_r} : '0);
      acc_p <= {acc_p[ACC_PW-2:0], 1'b0}
               + (h_sh[GAIN_W-1] ? {{GAIN_W{1'b0}}, p_r} : '0);
    end
  end

  // round half up on the magnitude, truncate the variance
  assign cmag     = rounded[GAIN_FRAC +: MAG_W];
  assign p_new    = acc_p[GAIN_FRAC +: VAR_W];
  assign sts.done = done;

endmodule

### sv/angle_kalman_filter.sv
// Top level of the one-state heading Kalman filter with angle wrapping.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------------
//  meas      | meas_valid/meas_ready | measured_angle[16:0] s, timestamp_ms[31:0], restart
//  est       | est_valid/est_ready   | filtered_angle[16:0] s
//  config    | APB psel/penable      | paddr[3:0], pwdata/prdata[31:0], pready tied high
//
// A seeding item (first after reset, or restart set) goes straight to the emit state
// and the output load. A tracking item passes through 10 multiply and 42 divide-by-1000
// predict steps, a variance add, 17 gain-divider and 17 multiply steps, three handoffs,
// the correction add, the estimate store and the output load, plus one wrap step per
// turn removed by the estimate wrap.
// Reset (rst, synchronous) restores the register defaults and unseeds the filter.
// One item is in work at a time. A new item is taken while the last result still
// waits in the output register; the next result holds in the emit state until it is free.
module angle_kalman_filter #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int VAR_WIDTH       = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // measurement items
  input  logic                               meas_valid,
  output logic                               meas_ready,
  input  logic signed [akf_pkg::ANGLE_W-1:0] measured_angle,
  input  logic        [akf_pkg::CFG_W-1:0]   timestamp_ms,
  input  logic                               restart,
  // estimate items
  output logic                               est_valid,
  input  logic                               est_ready,
  output logic signed [akf_pkg::ANGLE_W-1:0] filtered_angle,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [akf_pkg::PADDR_W-1:0] paddr,
  input  logic        [akf_pkg::CFG_W-1:0]   pwdata,
  output logic        [akf_pkg::CFG_W-1:0]   prdata,
  output logic                               pready
);
  import akf_pkg::*;

  localparam int SUM_W = ((VAR_WIDTH > CFG_W) ? VAR_WIDTH : CFG_W) + 1;
  localparam logic [SUM_W-1:0] VAR_MAX = {{(SUM_W-VAR_WIDTH){1'b0}}, {VAR_WIDTH{1'b1}}};

  // Working angles never reach 2^(WRAP_W-2); a larger half turn never wraps,
  // so it is capped there to stay representable.
  localparam int HALF_RAW = 180 << ANGLE_FRAC_BITS;
  localparam int HALF_LIM = (1 << (WRAP_W - 2)) - 1;
  localparam int HALF_CAP = (HALF_RAW > HALF_LIM) ? HALF_LIM : HALF_RAW;
  localparam logic signed [WRAP_W-1:0] HALF_TURN = WRAP_W'(HALF_CAP);
  localparam logic signed [WRAP_W-1:0] FULL_TURN = WRAP_W'(2 * HALF_CAP);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] process_noise;
  logic [CFG_W-1:0] measure_noise;
  logic [LIM_W-1:0] max_innovation;
  logic             cfg_wr;
  akf_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = akf_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise  <= CFG_W'(655);
      measure_noise  <= CFG_W'(65536);
      max_innovation <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PROCESS_NOISE: process_noise  <= pwdata;
        REG_MEASURE_NOISE: measure_noise  <= pwdata;
        REG_MAX_INNOV:     max_innovation <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PROCESS_NOISE: prdata = process_noise;
      REG_MEASURE_NOISE: prdata = measure_noise;
      REG_MAX_INNOV:     prdata = {{(CFG_W-LIM_W){1'b0}}, max_innovation};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Filter state and sequencer
  // ---------------------------------------------------------------------------
  akf_state_t                 state;
  logic                       seeded;
  logic                       pred_fin;
  logic signed [ANGLE_W-1:0]  est;
  logic [VAR_WIDTH-1:0]       var_p;
  logic [CFG_W-1:0]           last_time;
  logic signed [WRAP_W-1:0]   ang;      // innovation, then new estimate, while wrapping
  logic [MAG_W-1:0]           mag;
  logic                       neg;

  logic                       accept;
  logic                       seed_now;
  logic [CFG_W-1:0]           tdiff;
  logic [DT_W-1:0]            dt;
  logic                       in_range;
  logic signed [WRAP_W-1:0]   ang_step;
  logic signed [WRAP_W-1:0]   lim;
  logic signed [WRAP_W-1:0]   inn_c;
  logic [WRAP_W-1:0]          inn_abs;
  logic [SUM_W-1:0]           p_sum;
  logic [VAR_WIDTH-1:0]       p_sat;
  logic [SUM_W-1:0]           r_ext;
  logic [VAR_WIDTH-1:0]       r_sat;
  logic signed [WRAP_W-1:0]   corr;
  logic                       emit;

  akf_cmd_t          pred_cmd, div_cmd, mul_cmd;
  akf_sts_t          pred_sts, div_sts, mul_sts;
  logic [CFG_W-1:0]  inc;
  logic [GAIN_W-1:0] gain;
  logic [MAG_W-1:0]  cmag;
  logic [VAR_WIDTH-1:0] p_new;

  assign meas_ready = (state == S_IDLE);
  assign accept     = meas_valid & meas_ready;
  assign seed_now   = ~seeded | restart;
  assign emit       = (state == S_EMIT) & (~est_valid | est_ready);

  always_comb begin
    // elapsed time, clamped to 1..1000 ms (a backward step lands at 1000)
    tdiff = timestamp_ms - last_time;
    if (tdiff == '0) begin
      dt = DT_W'(1);
    end else if (tdiff > CFG_W'(DT_MAX)) begin
      dt = DT_W'(DT_MAX);
    end else begin
      dt = tdiff[DT_W-1:0];
    end

    // one turn removed per cycle; +/- half turn stays as is
    in_range = (ang <= HALF_TURN) && (ang >= -HALF_TURN);
    if (ang > HALF_TURN) begin
      ang_step = ang - FULL_TURN;
    end else if (ang < -HALF_TURN) begin
      ang_step = ang + FULL_TURN;
    end else begin
      ang_step = ang;
    end

    // innovation clamp, zero disables
    lim = signed'({{(WRAP_W-LIM_W){1'b0}}, max_innovation});
    if ((max_innovation != '0) && (ang > lim)) begin
      inn_c = lim;
    end else if ((max_innovation != '0) && (ang < -lim)) begin
      inn_c = -lim;
    end else begin
      inn_c = ang;
    end
    inn_abs = inn_c[WRAP_W-1] ? unsigned'(-inn_c) : unsigned'(inn_c);

    // saturating variance arithmetic
    p_sum = {{(SUM_W-VAR_WIDTH){1'b0}}, var_p} + {{(SUM_W-CFG_W){1'b0}}, inc};
    p_sat = (p_sum > VAR_MAX) ? {VAR_WIDTH{1'b1}} : p_sum[VAR_WIDTH-1:0];
    r_ext = {{(SUM_W-CFG_W){1'b0}}, measure_noise};
    r_sat = (r_ext > VAR_MAX) ? {VAR_WIDTH{1'b1}} : r_ext[VAR_WIDTH-1:0];

    corr = neg ? -signed'({1'b0, cmag}) : signed'({1'b0, cmag});

    pred_cmd.start = accept & ~seed_now;
    div_cmd.start  = (state == S_VADD);
    mul_cmd.start  = (state == S_GAIN) & div_sts.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seeded    <= 1'b0;
      pred_fin  <= 1'b0;
      est_valid <= 1'b0;
      est       <= '0;
      var_p     <= '0;
      last_time <= '0;
    end else begin
      if (emit) begin
        est_valid <= 1'b1;
      end else if (est_ready) begin
        est_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            last_time <= timestamp_ms;
            if (seed_now) begin
              est    <= measured_angle;
              var_p  <= r_sat;
              seeded <= 1'b1;
              state  <= S_EMIT;
            end else begin
              pred_fin <= 1'b0;
              state    <= S_PRED;
            end
          end
        end
        S_PRED: begin
          if (pred_sts.done) begin
            pred_fin <= 1'b1;
          end
          if ((pred_fin | pred_sts.done) & in_range) begin
            state <= S_VADD;
          end
        end
        S_VADD: begin
          var_p <= p_sat;
          state <= S_GAIN;
        end
        S_GAIN: begin
          if (div_sts.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            var_p <= p_new;
            state <= S_CORR;
          end
        end
        S_CORR: begin
          state <= S_EWRAP;
        end
        S_EWRAP: begin
          if (in_range) begin
            est   <= ang[ANGLE_W-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ang <= WRAP_W'(measured_angle) - WRAP_W'(est);
    end else if (((state == S_PRED) || (state == S_EWRAP)) && !in_range) begin
      ang <= ang_step;
    end else if (state == S_CORR) begin
      ang <= WRAP_W'(est) + corr;
    end

    if (state == S_VADD) begin
      mag <= inn_abs[MAG_W-1:0];
      neg <= inn_c[WRAP_W-1];
    end

    if (emit) begin
      filtered_angle <= est;
    end
  end

  // ---------------------------------------------------------------------------
  // Serial units
  // ---------------------------------------------------------------------------
  akf_predict u_predict (
    .clk (clk),
    .rst (rst),
    .cmd (pred_cmd),
    .q   (process_noise),
    .dt  (dt),
    .inc (inc),
    .sts (pred_sts)
  );

  akf_gain_div #(
    .VAR_W (VAR_WIDTH)
  ) u_gain_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .p    (p_sat),
    .r    (measure_noise),
    .gain (gain),
    .sts  (div_sts)
  );

  akf_update_mul #(
    .VAR_W (VAR_WIDTH)
  ) u_update_mul (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mul_cmd),
    .gain  (gain),
    .mag   (mag),
    .p     (var_p),
    .cmag  (cmag),
    .p_new (p_new),
    .sts   (mul_sts)
  );

endmodule
